[src/gblur_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gblur_pkg
// Shared types and constants for the multi-pass 3x3 binomial blur.
// ----------------------------------------------------------------------------
package gblur_pkg;

  // Default size limits, handed to the top level parameters
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int MAX_PASSES_DEF = 4;

  localparam int PIX_W   = 8;
  localparam int CFG_DW  = 9;   // widest register
  localparam int CFG_IW  = 2;
  localparam int PASS_W  = 3;   // blur_passes register width

  // Register indexes
  localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IW-1:0] REG_BLUR_PASSES  = 2'd2;

  // Register reset values
  localparam int WIDTH_RST  = 256;
  localparam int HEIGHT_RST = 256;
  localparam int PASSES_RST = 1;

  // Kernel [1 2 1; 2 4 2; 1 2 1] sums to 16
  localparam int SUM_SHIFT = 4;
  localparam int SUM_W     = PIX_W + SUM_SHIFT;

  // Token moving down the cell chain
  typedef struct packed {
    logic             valid;
    logic             pix;    // carries an image pixel (not a drain)
    logic             last;
    logic [PIX_W-1:0] value;
  } tok_t;

  // Result beat held in the output queue
  typedef struct packed {
    logic             last;
    logic [PIX_W-1:0] value;
  } res_t;

endpackage

[src/gblur_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gblur_cell
// One blur pass: two line buffers, 3x3 window, border copy, registered token.
// ----------------------------------------------------------------------------
module gblur_cell #(
  parameter int MAX_WIDTH  = gblur_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = gblur_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           clear,
  input  logic                           active,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]  width,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0] height,
  input  gblur_pkg::tok_t                tok_in,
  output gblur_pkg::tok_t                tok_out
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int LW = $clog2(MAX_WIDTH + 2);
  localparam int PW = gblur_pkg::PIX_W;
  localparam int SW = gblur_pkg::SUM_W;

  logic [2*PW-1:0] line_mem [MAX_WIDTH];  // {top, mid} per column
  logic [2*PW-1:0] rd_r;
  logic [AW-1:0]   col_r, col_nxt;
  logic [LW-1:0]   cnt_r, cnt_nxt;
  logic [HW-1:0]   row_r, row_nxt;
  logic [PW-1:0]   win_r [9];
  logic [PW-1:0]   win_nxt [9];
  gblur_pkg::tok_t tok_r, tok_nxt;

  logic            mem_we;
  logic [AW-1:0]   wm1, xq;
  logic [HW-1:0]   hm1;
  logic [LW-1:0]   lead;
  logic            emit, in_img, border, row_end;
  logic [SW-1:0]   sum;
  logic [PW-1:0]   top, mid;

  always_comb begin
    wm1     = AW'(width - WW'(1));
    hm1     = height - HW'(1);
    lead    = LW'(width) + LW'(1);
    top     = rd_r[2*PW-1:PW];
    mid     = rd_r[PW-1:0];
    mem_we  = adv && active && tok_in.valid && !clear;
    emit    = (cnt_r == lead);
    // column of the pixel leaving the window lags the write column by one
    xq      = (col_r == '0) ? wm1 : col_r - AW'(1);
    row_end = (xq == wm1);
    in_img  = (row_r != height);
    border  = (xq == '0) || row_end || (row_r == '0) || (row_r == hm1);

    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = top;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = mid;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = tok_in.value;

    sum = SW'(win_nxt[0]) + (SW'(win_nxt[1]) << 1) + SW'(win_nxt[2])
        + (SW'(win_nxt[3]) << 1) + (SW'(win_nxt[4]) << 2) + (SW'(win_nxt[5]) << 1)
        + SW'(win_nxt[6]) + (SW'(win_nxt[7]) << 1) + SW'(win_nxt[8]);

    col_nxt = col_r;
    cnt_nxt = cnt_r;
    row_nxt = row_r;
    tok_nxt = tok_r;
    if (clear) begin
      col_nxt = '0;
      cnt_nxt = '0;
      row_nxt = '0;
      tok_nxt = '0;
    end else if (adv) begin
      if (!active) begin
        tok_nxt = tok_in;
      end else begin
        tok_nxt = '0;
        if (tok_in.valid) begin
          col_nxt = (col_r == wm1) ? '0 : col_r + AW'(1);
          if (!emit) begin
            cnt_nxt = cnt_r + LW'(1);
          end else begin
            tok_nxt.valid = 1'b1;
            tok_nxt.pix   = in_img;
            tok_nxt.last  = in_img && row_end && (row_r == hm1);
            if (!in_img) begin
              tok_nxt.value = '0;
            end else if (border) begin
              tok_nxt.value = win_r[5];
            end else begin
              tok_nxt.value = sum[SW-1:gblur_pkg::SUM_SHIFT];
            end
            if (in_img && row_end) begin
              row_nxt = row_r + HW'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      cnt_r <= '0;
      row_r <= '0;
      tok_r <= '0;
    end else begin
      col_r <= col_nxt;
      cnt_r <= cnt_nxt;
      row_r <= row_nxt;
      tok_r <= tok_nxt;
    end
  end

  // Line store: write old mid as new top, pixel as new mid; read ahead at
  // the next column (write-first when a one-column row hits the same entry)
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[col_r] <= {mid, tok_in.value};
    end
    if (mem_we && (col_nxt == col_r)) begin
      rd_r <= {mid, tok_in.value};
    end else begin
      rd_r <= line_mem[col_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_r <= win_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

[src/gblur_outq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gblur_outq
// Two-entry output queue: output register plus skid entry.
// ----------------------------------------------------------------------------
module gblur_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  gblur_pkg::res_t push_data,
  output logic            full,
  output logic            out_valid,
  input  logic            out_ready,
  output gblur_pkg::res_t out_data
);

  logic [1:0]      count_r, count_nxt;
  gblur_pkg::res_t e0_r, e0_nxt;
  gblur_pkg::res_t e1_r, e1_nxt;
  logic            pop;

  always_comb begin
    pop       = (count_r != 2'd0) && out_ready;
    count_nxt = count_r;
    e0_nxt    = e0_r;
    e1_nxt    = e1_r;
    unique case ({push, pop})
      2'b10: begin
        if (count_r == 2'd0) begin
          e0_nxt = push_data;
        end else begin
          e1_nxt = push_data;
        end
        count_nxt = count_r + 2'd1;
      end
      2'b01: begin
        e0_nxt    = e1_r;
        count_nxt = count_r - 2'd1;
      end
      2'b11: begin
        if (count_r == 2'd1) begin
          e0_nxt = push_data;
        end else begin
          e0_nxt = e1_r;
          e1_nxt = push_data;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

  assign full      = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = e0_r;

endmodule

[src/gaussian_3x3_multipass_blur.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_3x3_multipass_blur
// Streaming 3x3 binomial blur, up to MAX_PASSES passes in a chain of cells.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake          Payload                      Role
//  in_      in_valid/in_ready   in_pixel_in[7:0], in_drain   pixel or drain token
//  out_     out_valid/out_ready out_pixel_out[7:0],          blurred pixel, raster
//                               out_last_pixel               order, last flag
//  cfg_     cfg_write_en        cfg_index[1:0], cfg_data[8:0] register write
//
//  One beat per cycle in and out while the output queue has room. Each
//  active pass answers width+1 tokens after its input; after that a token
//  is registered in each of the MAX_PASSES cells, then in the output queue.
//  Reset is synchronous; line buffers hold garbage until written, no clear
//  pass. in_ready comes from the queue fill only: it drops when two results
//  wait, and the whole chain freezes until out_ready frees an entry.
//  Any config write restarts the stream (position counters cleared).
//
module gaussian_3x3_multipass_blur #(
  parameter int MAX_WIDTH  = gblur_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = gblur_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_PASSES = gblur_pkg::MAX_PASSES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input beats
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [gblur_pkg::PIX_W-1:0]    in_pixel_in,
  input  logic                           in_drain,
  // result beats
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gblur_pkg::PIX_W-1:0]    out_pixel_out,
  output logic                           out_last_pixel,
  // config writes
  input  logic                           cfg_write_en,
  input  logic [gblur_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [gblur_pkg::CFG_DW-1:0]   cfg_data
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int PPW = $clog2(MAX_PASSES + 1);
  localparam int PW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int PRW = WW + HW;

  localparam int EFF_W_RST = (gblur_pkg::WIDTH_RST > MAX_WIDTH) ?
                             MAX_WIDTH : gblur_pkg::WIDTH_RST;
  localparam int EFF_H_RST = (gblur_pkg::HEIGHT_RST > MAX_HEIGHT) ?
                             MAX_HEIGHT : gblur_pkg::HEIGHT_RST;
  localparam int EFF_P_RST = (gblur_pkg::PASSES_RST > MAX_PASSES) ?
                             MAX_PASSES : gblur_pkg::PASSES_RST;
  localparam int TOTAL_RST = EFF_W_RST * EFF_H_RST;

  // Effective (clamped) config plus derived image size and bypass flag
  logic [WW-1:0]  eff_w_r, eff_w_nxt;
  logic [HW-1:0]  eff_h_r, eff_h_nxt;
  logic [PPW-1:0] eff_p_r, eff_p_nxt;
  logic [PW-1:0]  total_r, total_nxt;
  logic           bypass_r, bypass_nxt;

  // Tokens entered into the chain (or pixels passed in bypass), saturates
  logic [PW-1:0]  pos_r, pos_nxt;

  logic                  accept, adv, pos_lt, entry_pix;
  logic [MAX_PASSES-1:0] cell_active;
  gblur_pkg::tok_t       chain [MAX_PASSES+1];
  gblur_pkg::res_t       push_data, out_data;

  // --------------------------------------------------------------------------
  // Config registers: clamp on write, precompute width*height
  // --------------------------------------------------------------------------
  always_comb begin
    eff_w_nxt = eff_w_r;
    eff_h_nxt = eff_h_r;
    eff_p_nxt = eff_p_r;
    if (cfg_write_en) begin
      unique case (cfg_index)
        gblur_pkg::REG_IMAGE_WIDTH: begin
          eff_w_nxt = (32'(cfg_data) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_data);
        end
        gblur_pkg::REG_IMAGE_HEIGHT: begin
          eff_h_nxt = (32'(cfg_data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_data);
        end
        gblur_pkg::REG_BLUR_PASSES: begin
          eff_p_nxt = (32'(cfg_data[gblur_pkg::PASS_W-1:0]) > MAX_PASSES) ?
                      PPW'(MAX_PASSES) : PPW'(cfg_data[gblur_pkg::PASS_W-1:0]);
        end
        default: ;  // unused index: restart only
      endcase
    end
    total_nxt  = PW'(PRW'(eff_w_nxt) * PRW'(eff_h_nxt));
    bypass_nxt = (eff_w_nxt == '0) || (eff_h_nxt == '0) || (eff_p_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r  <= WW'(EFF_W_RST);
      eff_h_r  <= HW'(EFF_H_RST);
      eff_p_r  <= PPW'(EFF_P_RST);
      total_r  <= PW'(TOTAL_RST);
      bypass_r <= (EFF_P_RST == 0);
    end else begin
      eff_w_r  <= eff_w_nxt;
      eff_h_r  <= eff_h_nxt;
      eff_p_r  <= eff_p_nxt;
      total_r  <= total_nxt;
      bypass_r <= bypass_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Entry: turn an input beat into a chain token.
  // Bypass: pixels go straight through all cells, drains vanish.
  // Active: a drain before the image is complete is dropped; pixels past the
  // image become drains.
  // --------------------------------------------------------------------------
  assign accept = in_valid && in_ready;
  assign pos_lt = (pos_r < total_r);

  always_comb begin
    chain[0] = '0;
    if (bypass_r) begin
      chain[0].valid = accept && !in_drain;
      chain[0].pix   = 1'b1;
      chain[0].last  = (total_r != '0) && (pos_r == total_r - PW'(1));
      chain[0].value = in_pixel_in;
    end else begin
      chain[0].valid = accept && !(in_drain && pos_lt);
      chain[0].pix   = entry_pix;
      chain[0].value = entry_pix ? in_pixel_in : '0;
    end

    pos_nxt = pos_r;
    if (cfg_write_en) begin
      pos_nxt = '0;
    end else if (chain[0].valid && (pos_r != total_r)) begin
      pos_nxt = pos_r + PW'(1);
    end
  end

  assign entry_pix = !in_drain && pos_lt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Cell chain: pass s blurs when s < passes, else just registers the token.
  // Everything advances together whenever the output queue has room.
  // --------------------------------------------------------------------------
  for (genvar s = 0; s < MAX_PASSES; s++) begin : g_cell
    assign cell_active[s] = !bypass_r && (PPW'(s) < eff_p_r);

    gblur_cell #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .clear   (cfg_write_en),
      .active  (cell_active[s]),
      .width   (eff_w_r),
      .height  (eff_h_r),
      .tok_in  (chain[s]),
      .tok_out (chain[s+1])
    );
  end

  // --------------------------------------------------------------------------
  // Output queue: only pixel tokens leaving the last cell become results
  // --------------------------------------------------------------------------
  logic q_full;
  logic q_push;

  assign push_data.last  = chain[MAX_PASSES].last;
  assign push_data.value = chain[MAX_PASSES].value;
  assign q_push          = adv && chain[MAX_PASSES].valid && chain[MAX_PASSES].pix;

  gblur_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign adv            = !q_full;
  assign in_ready       = adv;
  assign out_pixel_out  = out_data.value;
  assign out_last_pixel = out_data.last;

endmodule

[src/gblur_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gblur_checker
// Port-level checks on the blur top level, bound in below.
// ----------------------------------------------------------------------------
module gblur_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [gblur_pkg::PIX_W-1:0] out_pixel_out,
  input logic                        out_last_pixel
);

  // Input side only backs up when results are waiting
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in_ready low with no result pending");

  // Input side blocks only when the queue fills without a result beat taken
  a_fall_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(in_ready) |-> $past(!(out_valid && out_ready)))
    else $error("in_ready fell in a cycle that took a result beat");

  // Input side reopens only after a result beat was taken
  a_rise_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(in_ready) |-> $past(out_valid && out_ready))
    else $error("in_ready rose without a result beat taken");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_out)
      && $stable(out_last_pixel))
    else $error("stalled result beat changed");

endmodule

bind gaussian_3x3_multipass_blur gblur_checker u_gblur_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_pixel_out  (out_pixel_out),
  .out_last_pixel (out_last_pixel)
);

[test/gaussian_3x3_multipass_blur_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_3x3_multipass_blur_tb
// Streams images of many sizes, pass counts and fill patterns through the
// blur chain and checks each result beat against a bit-exact software copy
// of the stage chain. Covers bypass, clamped sizes, early, extra and missing
// drains, aborted images, random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module gaussian_3x3_multipass_blur_tb;

  localparam int PIX_W          = gblur_pkg::PIX_W;
  localparam int CFG_IW         = gblur_pkg::CFG_IW;
  localparam int CFG_DW         = gblur_pkg::CFG_DW;
  localparam int PASS_W         = gblur_pkg::PASS_W;
  localparam int SUM_SHIFT      = gblur_pkg::SUM_SHIFT;
  localparam int MAX_WIDTH_DEF  = gblur_pkg::MAX_WIDTH_DEF;
  localparam int MAX_HEIGHT_DEF = gblur_pkg::MAX_HEIGHT_DEF;
  localparam int MAX_PASSES_DEF = gblur_pkg::MAX_PASSES_DEF;
  localparam int WIDTH_RST      = gblur_pkg::WIDTH_RST;
  localparam int HEIGHT_RST     = gblur_pkg::HEIGHT_RST;
  localparam int PASSES_RST     = gblur_pkg::PASSES_RST;

  localparam int CLK_HALF       = 4;          // 8 ns period
  localparam int RESET_CYCLES   = 4;
  // Tokens pass a register in every cell plus the output queue; leave margin.
  localparam int SETTLE_CYCLES  = 2 * MAX_PASSES_DEF + 8;
  // This limit only catches hangs; no legal run comes near it.
  localparam int CYCLE_LIMIT    = 2_000_000;
  // Input beats for the whole run, directed part included.
  localparam int ITEM_TARGET    = 1750;
  localparam int PRESSURE_HOLD  = 400;
  localparam int MAX_PRINTED    = 30;
  // Index 3 is not a register: a write there only restarts the stream.
  localparam logic [CFG_IW-1:0] REG_SPARE = 2'd3;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_FULL, FILL_EXTREMES, FILL_RAMP} fill_t;
  typedef enum int {RX_FULL, RX_PATTERN, RX_RANDOM} rx_mode_t;

  typedef struct {
    logic [PIX_W-1:0] pix;
    logic             drn;
  } token_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of every stage (two line buffers, a 3x3
  // window and a token position) and turns each accepted input beat into
  // zero or one expected result beat.
  // --------------------------------------------------------------------------
  class blur_scoreboard;
    logic [PIX_W-1:0]  lines [MAX_PASSES_DEF][2][MAX_WIDTH_DEF];
    logic [PIX_W-1:0]  win [MAX_PASSES_DEF][9];
    int unsigned       stage_pos [MAX_PASSES_DEF];
    int unsigned       bypass_pos;
    logic [CFG_DW-1:0] width_reg;
    logic [CFG_DW-1:0] height_reg;
    logic [PASS_W-1:0] passes_reg;
    gblur_pkg::res_t   expected_pixels[$];
    int                mismatches;
    int                checked;
    int                last_seen;

    function new();
      foreach (lines[s, l, x]) lines[s][l][x] = '0;
      foreach (win[s, k]) win[s][k] = '0;
      foreach (stage_pos[s]) stage_pos[s] = 0;
      bypass_pos = 0;
      width_reg  = CFG_DW'(WIDTH_RST);
      height_reg = CFG_DW'(HEIGHT_RST);
      passes_reg = PASS_W'(PASSES_RST);
      mismatches = 0;
      checked    = 0;
      last_seen  = 0;
    endfunction

    function int unsigned eff_width();
      return (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
    endfunction

    function int unsigned eff_height();
      return (height_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : height_reg;
    endfunction

    function int unsigned eff_passes();
      return (passes_reg > MAX_PASSES_DEF) ? MAX_PASSES_DEF : passes_reg;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    // Any write restarts the stream; windows and line buffers are kept.
    function void apply_write(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        gblur_pkg::REG_IMAGE_WIDTH: width_reg = val;
        gblur_pkg::REG_IMAGE_HEIGHT: height_reg = val;
        gblur_pkg::REG_BLUR_PASSES: passes_reg = val[PASS_W-1:0];
        default: ;
      endcase
      foreach (stage_pos[s]) stage_pos[s] = 0;
      bypass_pos = 0;
    endfunction

    // One stage takes one token. Returns 1 when it hands a token on;
    // is_pix tells pixel from drain, q is the position of that token.
    function bit blur_stage(int s, int unsigned w, int unsigned total,
                            logic [PIX_W-1:0] v, output bit is_pix,
                            output logic [PIX_W-1:0] outv, output int unsigned q);
      int unsigned      t;
      int unsigned      x;
      int unsigned      xq;
      int unsigned      yq;
      int unsigned      h;
      int unsigned      sum;
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      t   = stage_pos[s];
      x   = t % w;
      top = lines[s][0][x];
      mid = lines[s][1][x];
      lines[s][0][x] = mid;
      lines[s][1][x] = v;
      for (int r = 0; r < 3; r++) begin
        win[s][r*3]   = win[s][r*3+1];
        win[s][r*3+1] = win[s][r*3+2];
      end
      win[s][2] = top;
      win[s][5] = mid;
      win[s][8] = v;
      if (t != 32'hFFFF_FFFF) stage_pos[s] = t + 1;
      is_pix = 1'b0;
      outv   = '0;
      q      = 0;
      if (t < w + 1) return 1'b0;
      q = t - w - 1;
      if (q >= total) return 1'b1;
      xq = q % w;
      yq = q / w;
      h  = total / w;
      is_pix = 1'b1;
      if (xq == 0 || yq == 0 || xq + 1 == w || yq + 1 == h) begin
        outv = win[s][4];
      end else begin
        sum = win[s][0] + 2 * win[s][1] + win[s][2]
            + 2 * win[s][3] + 4 * win[s][4] + 2 * win[s][5]
            + win[s][6] + 2 * win[s][7] + win[s][8];
        outv = PIX_W'(sum >> SUM_SHIFT);
      end
      return 1'b1;
    endfunction

    // Returns 0 for a beat the block ignores: an early drain, or any drain in bypass.
    function bit note_beat(logic [PIX_W-1:0] pix, logic drn);
      int unsigned      w;
      int unsigned      h;
      int unsigned      p;
      int unsigned      total;
      int unsigned      q;
      bit               is_pix;
      bit               np;
      logic [PIX_W-1:0] v;
      logic [PIX_W-1:0] nv;
      gblur_pkg::res_t  r;
      w     = eff_width();
      h     = eff_height();
      p     = eff_passes();
      total = w * h;
      if (p == 0 || w == 0 || h == 0) begin
        if (drn) return 1'b0;
        r.value = pix;
        r.last  = (total != 0 && bypass_pos == total - 1);
        if (bypass_pos != 32'hFFFF_FFFF) bypass_pos++;
        expected_pixels.push_back(r);
        return 1'b1;
      end
      if (drn && stage_pos[0] < total) return 1'b0;
      is_pix = !drn && stage_pos[0] < total;
      v = is_pix ? pix : '0;
      q = 0;
      for (int s = 0; s < p; s++) begin
        if (!blur_stage(s, w, total, v, np, nv, q)) return 1'b1;
        is_pix = np;
        v      = nv;
      end
      if (!is_pix) return 1'b1;
      r.value = v;
      r.last  = (q == total - 1);
      expected_pixels.push_back(r);
      return 1'b1;
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task check_result(logic [PIX_W-1:0] pix, logic last);
      gblur_pkg::res_t want;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("result pixel %0d last %0b with none expected", pix, last));
        return;
      end
      want = expected_pixels.pop_front();
      if (pix !== want.value)
        report_mismatch($sformatf("result %0d: pixel %0d, want %0d", checked, pix, want.value));
      if (last !== want.last)
        report_mismatch($sformatf("result %0d: last %0b, want %0b", checked, last, want.last));
      checked++;
      if (want.last) last_seen++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT and stimulus signals; the stimulus ones are known from time zero
  // --------------------------------------------------------------------------
  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  logic [PIX_W-1:0]  in_pixel_in    = '0;
  logic              in_drain       = 1'b0;
  logic              out_valid;
  logic              out_ready      = 1'b0;
  logic [PIX_W-1:0]  out_pixel_out;
  logic              out_last_pixel;
  logic              cfg_write_en   = 1'b0;
  logic [CFG_IW-1:0] cfg_index      = '0;
  logic [CFG_DW-1:0] cfg_data       = '0;

  blur_scoreboard sb;
  token_t         token_q[$];
  bit             gaps_on = 1'b1;
  int unsigned    hold_request = 0;  // set by the stimulus, consumed by the receiver
  int unsigned    cycle_count = 0;
  int unsigned    beats_in = 0;
  int unsigned    tokens_used = 0;
  int unsigned    images_run = 0;
  int unsigned    cfg_writes = 0;

  gaussian_3x3_multipass_blur u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_in    (in_pixel_in),
    .in_drain       (in_drain),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_out  (out_pixel_out),
    .out_last_pixel (out_last_pixel),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Hang guard: ends the run if it takes far longer than any correct run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results still expected", cycle_count,
               sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: every accepted beat goes straight to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_pixel_out, out_last_pixel);
  end

  // --------------------------------------------------------------------------
  // Receiver: picks a ready mode for a random stretch (always ready, a
  // rotating 32-bit pattern, or random draws, ready three times in four).
  // A stimulus hold request overrides it, keeping ready low throughout.
  // --------------------------------------------------------------------------
  rx_mode_t    rx_mode    = RX_FULL;
  logic [31:0] rx_pattern = '0;
  int unsigned mode_left  = 0;
  int unsigned hold_left  = 0;

  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode    = rx_mode_t'($urandom_range(0, 2));
        rx_pattern = $urandom;
        mode_left  = $urandom_range(32, 256);
      end
      mode_left--;
      case (rx_mode)
        RX_FULL: out_ready <= 1'b1;
        RX_PATTERN: begin
          out_ready <= rx_pattern[0];
          rx_pattern = {rx_pattern[0], rx_pattern[31:1]};
        end
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. All of them start and end at a falling edge.
  // --------------------------------------------------------------------------

  // Register write: enable high for one cycle, then low before the task
  // returns, so back-to-back writes never drop and raise it in the same step.
  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    @(posedge clk);
    sb.apply_write(idx, val);
    cfg_writes++;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    @(negedge clk);
  endtask

  // Upper data bits of the passes write are junk the register must drop.
  task automatic configure(int unsigned w, int unsigned h, int unsigned p);
    write_reg(gblur_pkg::REG_IMAGE_WIDTH, CFG_DW'(w));
    write_reg(gblur_pkg::REG_IMAGE_HEIGHT, CFG_DW'(h));
    write_reg(gblur_pkg::REG_BLUR_PASSES, {6'($urandom), 3'(p)});
  endtask

  function automatic void push_token(logic [PIX_W-1:0] pix, logic drn);
    token_t tk;
    tk.pix = pix;
    tk.drn = drn;
    token_q.push_back(tk);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(fill_t fill, int unsigned i);
    case (fill)
      FILL_ZERO: return 8'd0;
      FILL_FULL: return 8'd255;
      FILL_EXTREMES: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
      FILL_RAMP: return 8'(i * 37);
      default: return 8'($urandom);
    endcase
  endfunction

  // Queues one image for the current setting: all pixels, then one
  // (width+1) drain run per pass; bypass gets pixels and stray drains.
  // A noisy image adds ignored early drains and a long or short tail.
  task automatic queue_image(fill_t fill, bit noisy);
    int unsigned w;
    int unsigned h;
    int unsigned p;
    int unsigned total;
    int unsigned n;
    w     = sb.eff_width();
    h     = sb.eff_height();
    p     = sb.eff_passes();
    total = w * h;
    if (p == 0 || total == 0) begin
      // bypass: pixels flow straight through, drains vanish
      n = (total != 0) ? total + $urandom_range(0, 3) : $urandom_range(1, 12);
      for (int unsigned i = 0; i < n; i++) begin
        push_token(pick_pixel(fill, i), 1'b0);
        if ($urandom_range(0, 7) == 0) push_token(8'($urandom), 1'b1);
      end
      return;
    end
    for (int unsigned i = 0; i < total; i++) begin
      push_token(pick_pixel(fill, i), 1'b0);
      if (noisy && i + 1 < total && $urandom_range(0, 15) == 0)
        push_token(8'($urandom), 1'b1);
    end
    n = p * (w + 1);
    if (noisy) begin
      case ($urandom_range(0, 2))
        0: n = n + $urandom_range(1, 6);
        1: n = $urandom_range(0, n - 1);
        default: ;
      endcase
    end
    for (int unsigned i = 0; i < n; i++) begin
      // past the image a pixel only acts as a drain
      if (noisy && $urandom_range(0, 5) == 0) push_token(8'($urandom), 1'b0);
      else push_token(8'($urandom), 1'b1);
    end
  endtask

  // Sends the queued tokens in bursts with random gaps (if enabled), then
  // waits for every expected result and lets the cell chain run empty.
  task automatic stream_and_drain();
    token_t tk;
    int     burst_left;
    burst_left = $urandom_range(1, 32);
    while (token_q.size() != 0) begin
      tk = token_q.pop_front();
      in_valid    <= 1'b1;
      in_pixel_in <= tk.pix;
      in_drain    <= tk.drn;
      do @(posedge clk); while (!in_ready);
      beats_in++;
      if (sb.note_beat(tk.pix, tk.drn)) tokens_used++;
      @(negedge clk);
      burst_left--;
      if (gaps_on && burst_left <= 0 && token_q.size() != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst_left = $urandom_range(1, 32);
      end
    end
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // a trailing drain may still be in a cell with nothing to show for it
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_image(int unsigned w, int unsigned h, int unsigned p, fill_t fill,
                           bit noisy);
    configure(w, h, p);
    queue_image(fill, noisy);
    stream_and_drain();
    images_run++;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned p;
    int unsigned keep;
    fill_t       fill;
    bit          noisy;

    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset setting (256 x 256, one pass): a partial first image just past
    // the first line, so a handful of top-row results come out.
    for (int i = 0; i < 264; i++) push_token(8'($urandom), 1'b0);
    stream_and_drain();

    // 3x3, one pass: cross of full-scale pixels on zero, an early drain in
    // the middle, the drain run, then an extra drain and an extra pixel.
    configure(3, 3, 1);
    push_token(8'd0, 1'b0);   push_token(8'd255, 1'b0); push_token(8'd0, 1'b0);
    push_token(8'd255, 1'b0); push_token(8'd255, 1'b0);
    push_token(8'hA5, 1'b1);  // too early, must be ignored
    push_token(8'd255, 1'b0);
    push_token(8'd0, 1'b0);   push_token(8'd255, 1'b0); push_token(8'd0, 1'b0);
    repeat (4) push_token(8'hFF, 1'b1);
    push_token(8'h5A, 1'b1);  // after the last result: gives nothing
    push_token(8'd1, 1'b0);   // pixel past the image acts as a drain
    stream_and_drain();

    // Zero passes: straight through, last flag on the fourth pixel, drains
    // dropped, a pixel past the image still comes out.
    configure(2, 2, 0);
    push_token(8'd255, 1'b0); push_token(8'd0, 1'b0);
    push_token(8'd128, 1'b0); push_token(8'd1, 1'b1);
    push_token(8'd1, 1'b0);   push_token(8'd77, 1'b0);
    stream_and_drain();

    // Zero width, then zero height with an oversized pass count: bypass with
    // no last flag at all.
    run_image(0, 3, 2, FILL_RANDOM, 1'b0);
    run_image(3, 0, 7, FILL_EXTREMES, 1'b0);
    // Pass count above the chain length clamps to every stage active.
    run_image(3, 3, 7, FILL_FULL, 1'b0);
    // Narrow images: everything is border.
    run_image(2, 5, 3, FILL_RANDOM, 1'b0);
    run_image(5, 1, 2, FILL_RAMP, 1'b0);
    run_image(1, 1, 4, FILL_RANDOM, 1'b0);

    // Size extremes: width above the limit clamps to a full 256-pixel row,
    // sent with no gaps.
    gaps_on = 1'b0;
    run_image(511, 1, 1, FILL_EXTREMES, 1'b0);
    gaps_on = 1'b1;
    // Output held off for a long stretch while the sender keeps offering:
    // the result queue fills and the input must stall. The image is also
    // taller than the height limit.
    hold_request = PRESSURE_HOLD;
    run_image(1, 300, 2, FILL_RAMP, 1'b0);

    // Random part: mostly small, well-formed images; now and then a wider
    // or taller one, a bypass setting, noise in the tail, or an image cut
    // short and restarted by a write to the spare index.
    while (beats_in < ITEM_TARGET) begin
      case ($urandom_range(0, 15))
        0: begin
          w = $urandom_range(13, 40);
          h = $urandom_range(1, 3);
        end
        1: begin
          w = $urandom_range(1, 4);
          h = $urandom_range(11, 40);
        end
        2: begin
          w = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 8);
          h = (w != 0) ? 0 : $urandom_range(1, 8);
        end
        default: begin
          w = $urandom_range(1, 12);
          h = $urandom_range(1, 10);
        end
      endcase
      case ($urandom_range(0, 15))
        0: p = 0;
        1: p = $urandom_range(5, 7);
        default: p = $urandom_range(1, 4);
      endcase
      fill       = fill_t'($urandom_range(0, 4));
      noisy      = ($urandom_range(0, 3) == 0);
      gaps_on    = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 5) == 0) begin
        configure(w, h, p);
        queue_image(fill, 1'b0);
        keep = $urandom_range(0, token_q.size());
        while (token_q.size() > keep) void'(token_q.pop_back());
        stream_and_drain();
        write_reg(REG_SPARE, CFG_DW'($urandom));
        queue_image(fill, noisy);
        stream_and_drain();
        images_run++;
      end else begin
        run_image(w, h, p, fill, noisy);
      end
    end

    $display("Run covered %0d images, %0d register writes, %0d input beats (%0d used)",
             images_run, cfg_writes, beats_in, tokens_used);
    $display("Checked %0d result beats, %0d of them image ends, %0d mismatches",
             sb.checked, sb.last_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
